FILE: hdl/ids_pkg.sv
// shared constants, types and functions for the isotropic direction sampler
`timescale 1ns / 1ps
package ids_pkg;

   localparam int RAND_BITS_DEF     = 32;
   localparam int OUT_FRAC_BITS_DEF = 30;
   localparam int WF                = 30;
   localparam int CORDIC_ITERS      = 30;
   localparam int ROOT_STEPS        = 32;
   localparam int ROOT_PER_STAGE    = 4;
   localparam int ROOT_STAGES       = ROOT_STEPS / ROOT_PER_STAGE;
   localparam int CORDIC_PER_STAGE  = 3;
   localparam int CORDIC_STAGES     = CORDIC_ITERS / CORDIC_PER_STAGE;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] PI_Q30          = 32'd3373259426;

   // angle and cordic datapath width: q2.30 plus guard
   localparam int AW = 34;

   typedef logic signed [AW-1:0] ang_type;

   // root stage state
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] res;
   } root_type;

   // cordic stage state
   typedef struct packed {
      ang_type x;
      ang_type y;
      ang_type z;
   } cordic_type;

   function automatic ang_type atan_q30(input int k);
      logic [29:0] t;
      unique case (k)
         0: t = 30'd843314856;
         1: t = 30'd497837829;
         2: t = 30'd263043836;
         3: t = 30'd133525158;
         4: t = 30'd67021687;
         5: t = 30'd33543515;
         6: t = 30'd16775850;
         7: t = 30'd8388437;
         8: t = 30'd4194282;
         9: t = 30'd2097149;
         10: t = 30'd1048575;
         default: t = 30'(1) << (30 - k);
      endcase
      return ang_type'({4'b0, t});
   endfunction

   // one restoring root step, bit = 2^(62-2k)
   function automatic root_type root_step(input root_type a, input int k);
      logic [63:0] bitv;
      logic [63:0] trial;
      root_type    r;
      bitv  = 64'd1 << (62 - 2 * k);
      trial = a.res + bitv;
      if (a.rem >= trial) begin
         r.rem = a.rem - trial;
         r.res = (a.res >> 1) + bitv;
      end else begin
         r.rem = a.rem;
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   // one cordic rotation with floor shifts
   function automatic cordic_type cordic_step(input cordic_type a, input int k);
      ang_type    dx;
      ang_type    dy;
      cordic_type r;
      dx = a.y >>> k;
      dy = a.x >>> k;
      if (!a.z[AW-1]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - atan_q30(k);
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + atan_q30(k);
      end
      return r;
   endfunction

   // align a random word to a 32-bit fraction
   function automatic logic [31:0] align32(input logic [63:0] a, input int rb);
      logic [63:0] m;
      m = (rb < 64) ? (a & ((64'd1 << rb) - 64'd1)) : a;
      if (rb >= 32) return 32'(m >> (rb - 32));
      return 32'(m << (32 - rb));
   endfunction

   // clamp to +-1 and rescale to the output format
   function automatic logic [31:0] to_out(input ang_type v, input int ofb);
      ang_type     c;
      logic        neg;
      logic [63:0] m;
      c = v;
      if (c > ang_type'(1 << WF)) c = ang_type'(1 << WF);
      if (c < -ang_type'(1 << WF)) c = -ang_type'(1 << WF);
      neg = c[AW-1];
      m   = 64'(neg ? -c : c);
      if (ofb >= WF) m = m << (ofb - WF);
      else m = m >> (WF - ofb);
      if (neg) m = 64'd0 - m;
      return m[31:0];
   endfunction

endpackage

FILE: hdl/ids_root_stage.sv
// pipeline stage of four square-root steps with a flow-through payload
`timescale 1ns / 1ps
module ids_root_stage #(
   parameter int FIRST = 0,
   parameter int PW    = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ids_pkg::root_type  in_root,
   input  logic [PW-1:0]      in_pay,
   output logic               out_valid,
   output ids_pkg::root_type  out_root,
   output logic [PW-1:0]      out_pay
);
   ids_pkg::root_type root_in;
   logic               valid_ff;
   ids_pkg::root_type  root_ff;
   logic [PW-1:0]      pay_ff;

   always_comb begin
      root_in = in_root;
      for (int i = 0; i < ids_pkg::ROOT_PER_STAGE; i++) begin
         root_in = ids_pkg::root_step(root_in, FIRST + i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root_in;
         pay_ff  <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_root  = root_ff;
   assign out_pay   = pay_ff;
endmodule

FILE: hdl/ids_cordic_stage.sv
// pipeline stage of three cordic rotations with a flow-through payload
`timescale 1ns / 1ps
module ids_cordic_stage #(
   parameter int FIRST = 0,
   parameter int PW    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  ids_pkg::cordic_type in_rot,
   input  logic [PW-1:0]       in_pay,
   output logic                out_valid,
   output ids_pkg::cordic_type out_rot,
   output logic [PW-1:0]       out_pay
);
   ids_pkg::cordic_type rot_in;
   logic                valid_ff;
   ids_pkg::cordic_type rot_ff;
   logic [PW-1:0]       pay_ff;

   always_comb begin
      rot_in = in_rot;
      for (int i = 0; i < ids_pkg::CORDIC_PER_STAGE; i++) begin
         rot_in = ids_pkg::cordic_step(rot_in, FIRST + i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff <= rot_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_pay   = pay_ff;
endmodule

FILE: hdl/isotropic_direction_sampler.sv
// top level of the pipelined isotropic direction sampler
`timescale 1ns / 1ps
// one request enters per cycle and one direction leaves per request, in order.
// from acceptance to rsp_valid the pipe is built of these stages in order:
// an input stage forms u, u*u and the residual angle, eight root stages of
// four steps give sqrt(1-u^2), two stages apply the cordic gain and the
// angle product, ten cordic stages of three rotations give cos and sin,
// and a final stage rotates by quadrant and clamps. the whole pipe advances
// together unless the output register holds a result under rsp_stall, so
// throughput is one request per clock whenever the consumer keeps up.
module isotropic_direction_sampler #(
   parameter int RAND_BITS     = ids_pkg::RAND_BITS_DEF,
   parameter int OUT_FRAC_BITS = ids_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_rand_polar,
   input  logic [31:0]         req_rand_azimuth,
   input  logic [63:0]         req_energy_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_dir_x,
   output logic signed [31:0]  rsp_dir_y,
   output logic signed [31:0]  rsp_dir_z,
   output logic [63:0]         rsp_energy_out
);
   localparam int AW = ids_pkg::AW;
   // payload through the root section: energy, u, quadrant, residual angle
   localparam int PW1 = 64 + AW + 2 + 32;
   // payload through the cordic section: energy, u, quadrant
   localparam int PW2 = 64 + AW + 2;

   // whole pipe moves unless a held result is stalled
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // input stage: alignment, u, 1-u^2 and angle residual
   logic [31:0]          r1;
   logic [31:0]          r2;
   logic signed [AW-1:0] u;
   logic [63:0]          usq;
   logic [63:0]          one_minus_in;
   logic [1:0]           quad;
   logic [31:0]          resid;

   always_comb begin
      r1    = ids_pkg::align32(64'(req_rand_polar), RAND_BITS);
      r2    = ids_pkg::align32(64'(req_rand_azimuth), RAND_BITS);
      u     = AW'($signed({1'b0, r1[31:1]})) - AW'(64'd1 << ids_pkg::WF);
      usq   = 64'(u * u) >> ids_pkg::WF;
      one_minus_in = ((64'd1 << ids_pkg::WF) - usq) << ids_pkg::WF;
      quad  = 2'((r2 + 32'h2000_0000) >> 30);
      resid = r2 - {quad, 30'd0};
   end

   logic            s0_valid_ff;
   ids_pkg::root_type s0_root_ff;
   logic [PW1-1:0]  s0_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_root_ff <= '{rem: one_minus_in, res: 64'd0};
         s0_pay_ff  <= {req_energy_in, u, quad, resid};
      end
   end

   // root section
   logic              rv [ids_pkg::ROOT_STAGES+1];
   ids_pkg::root_type rr [ids_pkg::ROOT_STAGES+1];
   logic [PW1-1:0]    rp [ids_pkg::ROOT_STAGES+1];
   assign rv[0] = s0_valid_ff;
   assign rr[0] = s0_root_ff;
   assign rp[0] = s0_pay_ff;

   for (genvar g = 0; g < ids_pkg::ROOT_STAGES; g++) begin : g_root
      ids_root_stage #(.FIRST(g * ids_pkg::ROOT_PER_STAGE), .PW(PW1)) u_stage (
         .clock, .reset, .adv,
         .in_valid(rv[g]), .in_root(rr[g]), .in_pay(rp[g]),
         .out_valid(rv[g+1]), .out_root(rr[g+1]), .out_pay(rp[g+1])
      );
   end

   // gain and angle products, first register
   logic [63:0]  t_root;
   logic [31:0]  rsd;
   logic         rsd_neg;
   logic [31:0]  rsd_mag;
   assign t_root  = rr[ids_pkg::ROOT_STAGES].res;
   assign rsd     = rp[ids_pkg::ROOT_STAGES][31:0];
   assign rsd_neg = rsd[31];
   assign rsd_mag = rsd_neg ? 32'(-rsd) : rsd;

   logic            m_valid_ff;
   logic [63:0]     xg_ff;
   logic [63:0]     zm_ff;
   logic            zneg_ff;
   logic [PW2-1:0]  m_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= rv[ids_pkg::ROOT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xg_ff    <= 64'(t_root[31:0]) * 64'(ids_pkg::CORDIC_GAIN_Q30);
         zm_ff    <= 64'(rsd_mag) * 64'(ids_pkg::PI_Q30);
         zneg_ff  <= rsd_neg;
         m_pay_ff <= rp[ids_pkg::ROOT_STAGES][PW1-1:32];
      end
   end

   // scaling into cordic start values, second register
   logic                c0_valid_ff;
   ids_pkg::cordic_type c0_rot_ff;
   logic [PW2-1:0]      c0_pay_ff;
   ids_pkg::ang_type    zs;
   assign zs = AW'(zm_ff >> 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_valid_ff <= 1'b0;
      end else if (adv) begin
         c0_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c0_rot_ff <= '{x: AW'(xg_ff >> ids_pkg::WF), y: '0, z: zneg_ff ? -zs : zs};
         c0_pay_ff <= m_pay_ff;
      end
   end

   // cordic section
   logic                cv [ids_pkg::CORDIC_STAGES+1];
   ids_pkg::cordic_type cr [ids_pkg::CORDIC_STAGES+1];
   logic [PW2-1:0]      cp [ids_pkg::CORDIC_STAGES+1];
   assign cv[0] = c0_valid_ff;
   assign cr[0] = c0_rot_ff;
   assign cp[0] = c0_pay_ff;

   for (genvar g = 0; g < ids_pkg::CORDIC_STAGES; g++) begin : g_cordic
      ids_cordic_stage #(.FIRST(g * ids_pkg::CORDIC_PER_STAGE), .PW(PW2)) u_stage (
         .clock, .reset, .adv,
         .in_valid(cv[g]), .in_rot(cr[g]), .in_pay(cp[g]),
         .out_valid(cv[g+1]), .out_rot(cr[g+1]), .out_pay(cp[g+1])
      );
   end

   // quadrant rotation and output clamp
   ids_pkg::cordic_type fin;
   logic [PW2-1:0]      fpay;
   logic [1:0]          fq;
   ids_pkg::ang_type    cos_v;
   ids_pkg::ang_type    sin_v;
   assign fin  = cr[ids_pkg::CORDIC_STAGES];
   assign fpay = cp[ids_pkg::CORDIC_STAGES];
   assign fq   = fpay[1:0];

   always_comb begin
      unique case (fq)
         2'd0: begin cos_v = fin.x;  sin_v = fin.y;  end
         2'd1: begin cos_v = -fin.y; sin_v = fin.x;  end
         2'd2: begin cos_v = -fin.x; sin_v = -fin.y; end
         default: begin cos_v = fin.y; sin_v = -fin.x; end
      endcase
   end

   logic        out_valid_ff;
   logic [31:0] x_ff;
   logic [31:0] y_ff;
   logic [31:0] z_ff;
   logic [63:0] e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cv[ids_pkg::CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= ids_pkg::to_out(fpay[AW+1:2], OUT_FRAC_BITS);
         y_ff <= ids_pkg::to_out(cos_v, OUT_FRAC_BITS);
         z_ff <= ids_pkg::to_out(sin_v, OUT_FRAC_BITS);
         e_ff <= fpay[PW2-1:AW+2];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_dir_x      = x_ff;
   assign rsp_dir_y      = y_ff;
   assign rsp_dir_z      = z_ff;
   assign rsp_energy_out = e_ff;
endmodule

FILE: hdl/ids_checker.sv
// port-level checker for the isotropic direction sampler and its bind
`timescale 1ns / 1ps
module ids_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_dir_x,
   input logic [63:0] rsp_energy_out
);
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)) else $error("stall without held result");

   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall) else $error("request taken while held");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_energy_out)))
      else $error("held result changed");

   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_dir_x, rsp_energy_out}))
      else $error("unknown bits on a valid result");
endmodule

bind isotropic_direction_sampler ids_checker u_ids_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_dir_x, .rsp_energy_out
);

FILE: verif/isotropic_direction_sampler_tb.sv
// self-checking testbench for the isotropic direction sampler
`timescale 1ns / 1ps
module isotropic_direction_sampler_tb;

   // one direction request as queued for the driver
   typedef struct {
      logic [31:0] polar;
      logic [31:0] azimuth;
      logic [63:0] energy;
   } dir_req_t;

   // one expected direction
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [63:0] energy;
   } dir_rsp_t;

   localparam int LATENCY = 22;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint ONE_Q30 = 64'sd1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_rand_polar = '0;
   logic [31:0] req_rand_azimuth = '0;
   logic [63:0] req_energy_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_dir_x;
   logic signed [31:0] rsp_dir_y;
   logic signed [31:0] rsp_dir_z;
   logic [63:0] rsp_energy_out;

   dir_req_t pending_reqs[$];
   dir_rsp_t expected_dirs[$];
   int error_count = 0;
   longint cycle_count = 0;
   bit quiet_mode = 1'b0;   // no idling in the last part of the run
   bit hold_sender = 1'b0;  // sender pauses until the pipe drains
   int send_gap = 0;
   int recv_gap = 0;

   isotropic_direction_sampler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rand_polar(req_rand_polar), .req_rand_azimuth(req_rand_azimuth),
      .req_energy_in(req_energy_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .rsp_energy_out(rsp_energy_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // floor shift of a signed value
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   // clamp to +-1 and keep low 32 bits (output format equals internal q.30)
   function automatic logic [31:0] clamp_unit(input longint v);
      if (v > ONE_Q30) v = ONE_Q30;
      if (v < -ONE_Q30) v = -ONE_Q30;
      return v[31:0];
   endfunction

   // predicted direction for one request
   function automatic dir_rsp_t predict_direction(input dir_req_t rq);
      longint atan_tab[30] = '{843314856, 497837829, 263043836, 133525158,
         67021687, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
         524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
         512, 256, 128, 64, 32, 16, 8, 4, 2};
      dir_rsp_t d;
      longint u, sq, x, y, z, rr, mag, dx, dy, c, sn;
      logic [63:0] rem, root, bitv, u2;
      logic [31:0] rw;
      logic [1:0] quad;
      u = longint'({1'b0, rq.polar[31:1]}) - ONE_Q30;
      u2 = 64'(u * u) >> 30;
      sq = ONE_Q30 - longint'(u2);
      // restoring integer root of (1-u^2) << 30
      rem = 64'(sq) << 30;
      root = 64'd0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      x = (longint'(root) * 64'sd652032874) >>> 30;
      y = 0;
      quad = 2'((33'(rq.azimuth) + 33'h20000000) >> 30);
      rw = rq.azimuth - (32'(quad) << 30);
      rr = longint'($signed(rw));
      mag = longint'((64'(rr < 0 ? -rr : rr) * 64'd3373259426) >> 31);
      z = rr < 0 ? -mag : mag;
      for (int k = 0; k < 30; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[k];
         end else begin
            x += dx; y -= dy; z += atan_tab[k];
         end
      end
      case (quad)
         2'd0: begin c = x; sn = y; end
         2'd1: begin c = -y; sn = x; end
         2'd2: begin c = -x; sn = -y; end
         default: begin c = y; sn = -x; end
      endcase
      d.x = clamp_unit(u);
      d.y = clamp_unit(c);
      d.z = clamp_unit(sn);
      d.energy = rq.energy;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   task automatic add_req(input logic [31:0] p, input logic [31:0] a,
                          input logic [63:0] e);
      dir_req_t rq;
      rq.polar = p; rq.azimuth = a; rq.energy = e;
      pending_reqs.push_back(rq);
   endtask

   // driver: the request at the queue front stays there until accepted
   always @(posedge clock) begin
      dir_req_t rq;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_dirs.push_back(predict_direction(pending_reqs.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
               send_gap <= $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (hold_sender || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               rq = pending_reqs[0];
               req_valid <= 1'b1;
               req_rand_polar <= rq.polar;
               req_rand_azimuth <= rq.azimuth;
               req_energy_in <= rq.energy;
            end
         end
      end
   end

   // monitor and receiver idling
   always @(posedge clock) begin
      dir_rsp_t d;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dirs.size() == 0) begin
               report_mismatch("unexpected response", rsp_energy_out, 64'd0);
            end else begin
               d = expected_dirs.pop_front();
               if (rsp_dir_x !== d.x)
                  report_mismatch("dir_x", {32'd0, rsp_dir_x}, {32'd0, d.x});
               if (rsp_dir_y !== d.y)
                  report_mismatch("dir_y", {32'd0, rsp_dir_y}, {32'd0, d.y});
               if (rsp_dir_z !== d.z)
                  report_mismatch("dir_z", {32'd0, rsp_dir_z}, {32'd0, d.z});
               if (rsp_energy_out !== d.energy)
                  report_mismatch("energy_out", rsp_energy_out, d.energy);
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycle limit watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [31:0] p, a;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: polar extremes, quadrant edges of the azimuth, energy extremes
      add_req(32'h0000_0000, 32'h0000_0000, 64'h0);
      add_req(32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
      add_req(32'h8000_0000, 32'h4000_0000, 64'h5555_5555_5555_5555);
      add_req(32'h7fff_ffff, 32'h8000_0000, 64'haaaa_aaaa_aaaa_aaaa);
      add_req(32'h8000_0001, 32'hc000_0000, 64'h1);
      add_req(32'h0000_0001, 32'h2000_0000, 64'h8000_0000_0000_0000);
      add_req(32'hffff_fffe, 32'h1fff_ffff, 64'h7fff_ffff_ffff_ffff);
      add_req(32'h4000_0000, 32'h6000_0000, 64'h0123_4567_89ab_cdef);
      add_req(32'hc000_0000, 32'h5fff_ffff, 64'hfedc_ba98_7654_3210);
      add_req(32'h8000_0000, 32'ha000_0000, 64'h3ff0_0000_0000_0000);
      add_req(32'h8000_0000, 32'he000_0000, 64'h2);
      add_req(32'h9234_5678, 32'hdfff_ffff, 64'h4);
      add_req(32'h0000_0002, 32'h0000_0001, 64'h8);
      add_req(32'h8000_0000, 32'h0000_0000, 64'h10);
      wait (pending_reqs.size() == 0);
      // sender holds off until every expected direction has arrived
      hold_sender = 1'b1;
      wait (expected_dirs.size() == 0 && !req_valid);
      hold_sender = 1'b0;
      for (int i = 0; i < 600; i++) begin
         p = $urandom;
         a = $urandom;
         case ($urandom_range(0, 7))
            0: p = $urandom_range(0, 3);
            1: p = 32'hffff_ffff - $urandom_range(0, 3);
            2: p = 32'h8000_0000 + $urandom_range(0, 4) - 2;
            3: a = {2'($urandom), 30'h2000_0000} + $urandom_range(0, 2) - 1;
            default: ;
         endcase
         add_req(p, a, {$urandom, $urandom});
         if (i == 450) begin
            wait (pending_reqs.size() == 0);
            quiet_mode = 1'b1;
         end
      end
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_dirs.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && expected_dirs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
